// ===== design/ptt_pkg.sv =====
// ============================================================================
// ptt_pkg
// Shared types and codes for the periodic timer table: opcodes, result kinds,
// the command word that travels from the front end to the engine, and status.
// ============================================================================
package ptt_pkg;

   // fixed field widths of the channel words
   localparam int FIELD_W = 32;
   localparam int SLOT_W  = 4;
   localparam int OP_W    = 2;

   // request opcodes
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_CREATE = 2'd0;
   localparam op_type OP_KILL   = 2'd1;
   localparam op_type OP_TICK   = 2'd2;

   // result kinds
   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_KILL   = 2'd1,
      KIND_FIRE   = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   // classified command held in the queue
   // create: arg_a = period, arg_b = first delay; tick: arg_a = elapsed time
   typedef struct packed {
      op_type             opcode;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] arg_a;
      logic [FIELD_W-1:0] arg_b;
      logic [FIELD_W-1:0] repeats;
   } cmd_type;

   // queue head as seen by the engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   // engine status for checking
   typedef struct packed {
      logic walking;
      logic done_wait;
      logic pop;
      logic done_emit;
   } eng_stat_type;

   // engine sequencer states
   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_WALK,
      ENG_DONE
   } eng_state_type;

endpackage

// ===== design/ptt_if.sv =====
// ============================================================================
// ptt_if
// Request and response channels of the periodic timer table, each with a
// valid/ready handshake and its payload fields.
// ============================================================================
interface ptt_req_if;
   import ptt_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [SLOT_W-1:0]  slot;
   logic [FIELD_W-1:0] period_us;
   logic [FIELD_W-1:0] first_delay_us;
   logic [FIELD_W-1:0] repeat_count;
   logic [FIELD_W-1:0] elapsed_us;

   modport source (
      output valid, opcode, slot, period_us, first_delay_us, repeat_count, elapsed_us,
      input  ready
   );

   modport sink (
      input  valid, opcode, slot, period_us, first_delay_us, repeat_count, elapsed_us,
      output ready
   );
endinterface

interface ptt_rsp_if;
   import ptt_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [SLOT_W-1:0] slot_res;
   logic              ok;
   logic              expired;
   logic              last;

   modport source (
      output valid, kind, slot_res, ok, expired, last,
      input  ready
   );

   modport sink (
      input  valid, kind, slot_res, ok, expired, last,
      output ready
   );
endinterface

// ===== design/ptt_ram.sv =====
// ============================================================================
// ptt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module ptt_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ptt_front.sv =====
// ============================================================================
// ptt_front
// Request front end: takes request words, drops unknown opcodes, trims the
// time fields to the timer width and packs a command word for the queue.
// ============================================================================
module ptt_front #(
   parameter int TIME_WIDTH = 32
) (
   ptt_req_if.sink          req,
   input  logic             queue_full,
   output logic             push,
   output ptt_pkg::cmd_type push_cmd
);
   import ptt_pkg::*;

   localparam logic [FIELD_W-1:0] TIME_MASK = (TIME_WIDTH >= FIELD_W) ? '1 :
      FIELD_W'((64'd1 << TIME_WIDTH) - 64'd1);

   logic known_op;

   // a word is taken whenever the queue has room
   assign req.ready = !queue_full;

   // classify and pack
   always_comb begin
      known_op         = 1'b0;
      push_cmd.opcode  = req.opcode;
      push_cmd.slot    = req.slot;
      push_cmd.arg_a   = '0;
      push_cmd.arg_b   = '0;
      push_cmd.repeats = '0;
      unique case (req.opcode)
         OP_CREATE: begin
            known_op         = 1'b1;
            push_cmd.arg_a   = req.period_us & TIME_MASK;
            push_cmd.arg_b   = req.first_delay_us & TIME_MASK;
            push_cmd.repeats = req.repeat_count;
         end
         OP_KILL: begin
            known_op = 1'b1;
         end
         OP_TICK: begin
            known_op       = 1'b1;
            push_cmd.arg_a = req.elapsed_us & TIME_MASK;
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   assign push = req.valid && !queue_full && known_op;

endmodule

// ===== design/ptt_queue.sv =====
// ============================================================================
// ptt_queue
// Two-entry command queue between the front end and the engine, so that each
// side can stall on its own.
// ============================================================================
module ptt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ptt_pkg::cmd_type       push_cmd,
   output logic                   full,
   input  logic                   pop,
   output ptt_pkg::queue_out_type q_out
);
   import ptt_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full   = (count_ff == 2'd2);
   assign do_pop = pop && (count_ff != 2'd0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.cmd   = entry_ff[rd_ptr_ff];

endmodule

// ===== design/ptt_engine.sv =====
// ============================================================================
// ptt_engine
// Timer engine: executes create and kill commands in one step and walks the
// slot stores one slot per cycle for a tick, holding while a fire word waits, then closes
// it with a done word. Owns the slot flags, the timer stores and the response register.
// ============================================================================
module ptt_engine #(
   parameter int SLOTS      = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptt_pkg::queue_out_type q_out,
   output logic                   pop,
   ptt_rsp_if.source              rsp,
   output ptt_pkg::eng_stat_type  stat
);
   import ptt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TW    = (TIME_WIDTH < FIELD_W) ? TIME_WIDTH : FIELD_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   eng_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [TW-1:0]      elapsed_ff, elapsed_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [SLOTS-1:0]   marked_ff, marked_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic               rsp_expired_ff, rsp_expired_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic               period_we, count_we, reps_we;
   logic [TW-1:0]      period_wd, count_wd;
   logic [FIELD_W-1:0] reps_wd;
   logic [TW-1:0]      period_q, count_q;
   logic [FIELD_W-1:0] reps_q;

   logic               out_free;
   logic               free_found;
   logic [IDX_W-1:0]   free_idx;
   logic               kill_ok;
   logic [IDX_W-1:0]   kill_idx;
   logic               cur_valid, cur_marked, no_fire, need_fire, advance;
   logic               expire;
   logic               done_emit;

   // timer stores
   ptt_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (period_we),
      .wr_addr (wr_addr),
      .wr_data (period_wd),
      .rd_addr (rd_addr),
      .rd_data (period_q)
   );

   ptt_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (wr_addr),
      .wr_data (count_wd),
      .rd_addr (rd_addr),
      .rd_data (count_q)
   );

   ptt_ram #(.WIDTH(FIELD_W), .DEPTH(SLOTS)) u_reps_ram (
      .clock   (clock),
      .wr_en   (reps_we),
      .wr_addr (wr_addr),
      .wr_data (reps_wd),
      .rd_addr (rd_addr),
      .rd_data (reps_q)
   );

   // response register can take a new word
   assign out_free = !rsp_valid_ff || rsp.ready;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // kill target check
   assign kill_idx = IDX_W'(q_out.cmd.slot);
   assign kill_ok  = (int'(q_out.cmd.slot) < SLOTS) && valid_ff[kill_idx];

   // current slot of the walk
   assign cur_valid  = valid_ff[rd_idx_ff];
   assign cur_marked = marked_ff[rd_idx_ff];
   assign no_fire    = elapsed_ff < count_q;
   assign need_fire  = cur_valid && !cur_marked && !no_fire;
   assign advance    = !need_fire || out_free;
   assign expire     = (reps_q == FIELD_W'(1));

   // sequencer
   always_comb begin
      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff;
      elapsed_in     = elapsed_ff;
      valid_in       = valid_ff;
      marked_in      = marked_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;
      done_emit      = 1'b0;
      rd_addr        = rd_idx_ff;
      wr_addr        = rd_idx_ff;
      period_we      = 1'b0;
      count_we       = 1'b0;
      reps_we        = 1'b0;
      period_wd      = TW'(q_out.cmd.arg_a);
      count_wd       = TW'(q_out.cmd.arg_b);
      reps_wd        = q_out.cmd.repeats;

      unique case (state_ff)
         ENG_IDLE: begin
            rd_addr = '0;
            if (q_out.valid) begin
               unique case (q_out.cmd.opcode)
                  OP_CREATE: begin
                     if (out_free) begin
                        pop            = 1'b1;
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = KIND_CREATE;
                        rsp_slot_in    = '0;
                        rsp_ok_in      = free_found;
                        rsp_expired_in = 1'b0;
                        rsp_last_in    = 1'b1;
                        if (free_found) begin
                           wr_addr             = free_idx;
                           period_we           = 1'b1;
                           count_we            = 1'b1;
                           reps_we             = 1'b1;
                           valid_in[free_idx]  = 1'b1;
                           marked_in[free_idx] = 1'b0;
                           rsp_slot_in         = SLOT_W'(free_idx);
                        end
                     end
                  end
                  OP_KILL: begin
                     if (out_free) begin
                        pop            = 1'b1;
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = KIND_KILL;
                        rsp_slot_in    = q_out.cmd.slot;
                        rsp_ok_in      = kill_ok;
                        rsp_expired_in = 1'b0;
                        rsp_last_in    = 1'b1;
                        if (kill_ok) begin
                           marked_in[kill_idx] = 1'b1;
                        end
                     end
                  end
                  OP_TICK: begin
                     pop        = 1'b1;
                     elapsed_in = TW'(q_out.cmd.arg_a);
                     rd_idx_in  = '0;
                     state_in   = ENG_WALK;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end

         ENG_WALK: begin
            if (advance) begin
               // per-slot update
               if (cur_valid) begin
                  if (cur_marked) begin
                     valid_in[rd_idx_ff]  = 1'b0;
                     marked_in[rd_idx_ff] = 1'b0;
                  end else if (no_fire) begin
                     count_we = 1'b1;
                     count_wd = count_q - elapsed_ff;
                  end else begin
                     count_we       = 1'b1;
                     count_wd       = period_q;
                     rsp_valid_in   = 1'b1;
                     rsp_kind_in    = KIND_FIRE;
                     rsp_slot_in    = SLOT_W'(rd_idx_ff);
                     rsp_ok_in      = 1'b1;
                     rsp_expired_in = 1'b0;
                     rsp_last_in    = 1'b0;
                     if (reps_q != '0) begin
                        reps_we = 1'b1;
                        reps_wd = reps_q - FIELD_W'(1);
                        if (expire) begin
                           valid_in[rd_idx_ff]  = 1'b0;
                           marked_in[rd_idx_ff] = 1'b0;
                           rsp_expired_in       = 1'b1;
                        end
                     end
                  end
               end
               // step to the next slot
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ENG_DONE;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
                  rd_addr   = rd_idx_ff + IDX_W'(1);
               end
            end
         end

         ENG_DONE: begin
            if (out_free) begin
               done_emit      = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_DONE;
               rsp_slot_in    = '0;
               rsp_ok_in      = 1'b1;
               rsp_expired_in = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = ENG_IDLE;
            end
         end

         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         valid_ff     <= '0;
         marked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         marked_ff    <= marked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and response payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      elapsed_ff     <= elapsed_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // response channel
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_kind_ff;
   assign rsp.slot_res = rsp_slot_ff;
   assign rsp.ok       = rsp_ok_ff;
   assign rsp.expired  = rsp_expired_ff;
   assign rsp.last     = rsp_last_ff;

   // status
   assign stat.walking   = (state_ff == ENG_WALK);
   assign stat.done_wait = (state_ff == ENG_DONE);
   assign stat.pop       = pop;
   assign stat.done_emit = done_emit;

endmodule

// ===== design/periodic_timer_table.sv =====
// ============================================================================
// periodic_timer_table
// Bank of periodic timers with repeat counts. Create and kill words are
// answered with one reply each; a tick walks every slot, sending a fire word
// for each timer that runs out, and ends with a done word.
// ============================================================================
// response path: an accepted create or kill word is written into the command queue;
//    an idle engine takes it from the queue head and loads the reply into the response register
// throughput: create and kill one word per cycle while the sink takes each reply; a tick
//    holds the engine for a walk of the timer stores at one slot per cycle and a done step,
//    and the walk stalls while a fire or done word waits on the sink
// reset: synchronous; clears slot flags, the command queue and the response
//    register; timer stores are written on create and need no clearing
module periodic_timer_table #(
   parameter int SLOTS      = 16,
   parameter int TIME_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   ptt_req_if.sink   req_chan,
   ptt_rsp_if.source rsp_chan
);
   import ptt_pkg::*;

   logic          push;
   cmd_type       push_cmd;
   logic          queue_full;
   logic          pop;
   queue_out_type q_out;
   eng_stat_type  stat;

   // accept and classify
   ptt_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // command queue
   ptt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .q_out    (q_out)
   );

   // execute
   ptt_engine #(.SLOTS(SLOTS), .TIME_WIDTH(TIME_WIDTH)) u_engine (
      .clock (clock),
      .reset (reset),
      .q_out (q_out),
      .pop   (pop),
      .rsp   (rsp_chan),
      .stat  (stat)
   );

   // commands leave the queue only while the engine is idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> (!stat.walking && !stat.done_wait))
      else $error("command popped while a tick is in progress");

   // a fresh fire word is only loaded during a walk
   a_fire_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == KIND_FIRE &&
       !$past(rsp_chan.valid && !rsp_chan.ready)) |-> $past(stat.walking))
      else $error("fire word produced outside a tick walk");

   // the done word ends the tick
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      stat.done_emit |=> (!stat.walking && !stat.done_wait))
      else $error("engine did not return to idle after the done word");

endmodule
